// ===== sv/hashed_score_cache_probe_defines.svh =====
// Assertion macros for the hashed score cache probe.
// Included by the top level; no other dependencies.
`ifndef HASHED_SCORE_CACHE_PROBE_DEFINES_SVH
`define HASHED_SCORE_CACHE_PROBE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define HCP_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcp assertion failed");
// Next-cycle implication, disabled during reset.
`define HCP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcp assertion failed");
`else
`define HCP_ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define HCP_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== sv/hcp_pkg.sv =====
// Shared types, constants and hash helpers for the hashed score cache probe.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hcp_pkg;

   localparam int unsigned VERTICES_DEFAULT = 32;
   localparam int unsigned SLOTS_PER_TABLE  = 128;
   localparam int unsigned SLOT_BITS        = $clog2(SLOTS_PER_TABLE);
   localparam int unsigned MAX_KEY_LENGTH   = 8;
   localparam int unsigned ELEM_BITS        = 5;
   localparam int unsigned KEY_BITS         = MAX_KEY_LENGTH * ELEM_BITS;
   localparam int unsigned LEN_BITS         = 4;
   localparam int unsigned NODE_BITS        = 5;
   localparam int unsigned HASH_BITS        = 64;
   localparam int unsigned SCORE_BITS       = 64;
   localparam int unsigned PROBE_BITS       = 8;
   localparam int unsigned FILL_BITS        = $clog2(SLOTS_PER_TABLE + 1);
   localparam int unsigned QUEUE_DEPTH      = 2;
   localparam int unsigned QPTR_BITS        = $clog2(QUEUE_DEPTH);

   localparam logic [HASH_BITS-1:0] FNV_BASIS = 64'hcbf29ce484222325;
   // The FNV prime is 2^40 + 0x1b3, so the fold is a shift plus a narrow product.
   localparam logic [8:0]           FNV_PRIME_LOW   = 9'h1b3;
   localparam int unsigned          FNV_PRIME_SHIFT = 40;
   localparam logic [HASH_BITS-1:0] MIX_A = 64'hff51afd7ed558ccd;
   localparam logic [HASH_BITS-1:0] MIX_B = 64'hc4ceb9fe1a85ec53;
   localparam int unsigned          MIX_SHIFT = 33;
   localparam int unsigned          LOAD_NUM  = 3;
   localparam int unsigned          LOAD_DEN  = 5;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_INSERT = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_KEY_TOO_LONG = 2'd1,
      STATUS_TABLE_FULL   = 2'd2,
      STATUS_NO_MISS      = 2'd3
   } status_type;

   // One classified lookup or insert waiting for the back end.
   typedef struct packed {
      logic                  is_insert;
      logic [NODE_BITS-1:0]  node;
      logic [HASH_BITS-1:0]  hash;
      logic [LEN_BITS-1:0]   length;
      logic [KEY_BITS-1:0]   key;
      logic                  overflow;
      logic [SCORE_BITS-1:0] score;
   } job_type;

   // One slot of a vertex table.
   typedef struct packed {
      logic                  valid;
      logic [HASH_BITS-1:0]  hash;
      logic [LEN_BITS-1:0]   length;
      logic [KEY_BITS-1:0]   key;
      logic [SCORE_BITS-1:0] score;
   } slot_entry_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // One FNV-1a step: xor in the value, multiply by the prime.
   function automatic logic [HASH_BITS-1:0] fnv_fold(input logic [HASH_BITS-1:0] h,
                                                     input logic [HASH_BITS-1:0] v);
      logic [HASH_BITS-1:0] x;
      x = h ^ v;
      return (x << FNV_PRIME_SHIFT) + HASH_BITS'(x * FNV_PRIME_LOW);
   endfunction

   function automatic logic [HASH_BITS-1:0] xorshift_mix(input logic [HASH_BITS-1:0] h);
      return h ^ (h >> MIX_SHIFT);
   endfunction

endpackage
`default_nettype wire

// ===== sv/hcp_channels.sv =====
// Request and response channel interfaces of the hashed score cache probe.
// Depends on hcp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface hcp_req_if import hcp_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [1:0]            command;
   logic [NODE_BITS-1:0]  node;
   logic [ELEM_BITS-1:0]  key_element;
   logic [SCORE_BITS-1:0] score;

   modport source(output valid, command, node, key_element, score, input ready);
   modport sink(input valid, command, node, key_element, score, output ready);
endinterface

interface hcp_rsp_if import hcp_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic                  result_kind;
   logic                  hit;
   logic [SCORE_BITS-1:0] found_score;
   logic [1:0]            status;
   logic [PROBE_BITS-1:0] probe_count;

   modport source(output valid, result_kind, hit, found_score, status, probe_count,
                  input ready);
   modport sink(input valid, result_kind, hit, found_score, status, probe_count,
                output ready);
endinterface
`default_nettype wire

// ===== sv/hcp_queue.sv =====
// Two-word queue of classified jobs between front and back end.
// Depends on hcp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hcp_queue import hcp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type q_stat
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = QPTR_BITS'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = QPTR_BITS'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// ===== sv/hcp_front.sv =====
// Front end: accepts request words, gathers the pending key and its running
// FNV-1a hash, and queues lookups and inserts. Depends on hcp_pkg, hcp_channels.
`timescale 1ns / 1ps
`default_nettype none
module hcp_front import hcp_pkg::*; #(
   parameter int unsigned VERTICES = VERTICES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   hcp_req_if.sink          req_ch,
   input  back_status_type  back_stat,
   input  queue_status_type q_stat,
   output logic             job_push,
   output job_type          job
);

   localparam int unsigned NODE_CODES = 2 ** NODE_BITS;

   logic [HASH_BITS-1:0] hash_ff, hash_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic                 ovf_ff, ovf_in;
   logic                 accept;
   logic [NODE_BITS-1:0] node_wrap [NODE_CODES];

   // Node numbers wrap onto the vertex range through a constant table.
   for (genvar g = 0; g < NODE_CODES; g++) begin : g_wrap
      assign node_wrap[g] = NODE_BITS'(g % VERTICES);
   end

   assign req_ch.ready = !back_stat.clearing && !q_stat.full;
   assign accept       = req_ch.valid && req_ch.ready;

   // Classify the word and keep the pending key.
   always_comb begin
      hash_in  = hash_ff;
      key_in   = key_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      job_push = 1'b0;
      job      = '0;
      job.node     = node_wrap[req_ch.node];
      job.hash     = hash_ff;
      job.length   = len_ff;
      job.key      = key_ff;
      job.overflow = ovf_ff;
      job.score    = req_ch.score;
      if (accept) begin
         case (command_type'(req_ch.command))
            CMD_APPEND: begin
               if (len_ff == LEN_BITS'(MAX_KEY_LENGTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  for (int k = 0; k < MAX_KEY_LENGTH; k++) begin
                     if (len_ff == LEN_BITS'(k)) begin
                        key_in[k*ELEM_BITS +: ELEM_BITS] = req_ch.key_element;
                     end
                  end
                  len_in  = LEN_BITS'(len_ff + 1'b1);
                  hash_in = fnv_fold(hash_ff, HASH_BITS'(req_ch.key_element));
               end
            end
            CMD_LOOKUP: begin
               job_push = 1'b1;
               hash_in  = FNV_BASIS;
               key_in   = '0;
               len_in   = '0;
               ovf_in   = 1'b0;
            end
            CMD_INSERT: begin
               job_push      = 1'b1;
               job.is_insert = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
         key_ff  <= '0;
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         key_ff  <= key_in;
         len_ff  <= len_in;
         ovf_ff  <= ovf_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/hcp_back.sv =====
// Back end: finishes the hash on a shared 32x32 multiplier, probes the slot
// memory linearly, performs inserts and drives the response register.
// Depends on hcp_pkg and hcp_channels.
`timescale 1ns / 1ps
`default_nettype none
module hcp_back import hcp_pkg::*; #(
   parameter int unsigned VERTICES = VERTICES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            job_valid,
   input  job_type         job,
   output logic            job_pop,
   hcp_rsp_if.source       rsp_ch,
   output back_status_type back_stat
);

   localparam int unsigned TOTAL_SLOTS = VERTICES * SLOTS_PER_TABLE;
   localparam int unsigned ADDR_BITS   = $clog2(TOTAL_SLOTS);
   localparam int unsigned FADDR_BITS  = (VERTICES > 1) ? $clog2(VERTICES) : 1;
   localparam int unsigned NEED_BITS   = FILL_BITS + 3;
   localparam logic [NEED_BITS-1:0] ROOM = NEED_BITS'(SLOTS_PER_TABLE * LOAD_NUM);
   localparam logic [SLOT_BITS-1:0] LAST_STEP = SLOT_BITS'(SLOTS_PER_TABLE - 1);
   localparam logic [PROBE_BITS-1:0] PROBE_MAX = '1;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_MIX   = 5'b00100,
      ST_READ  = 5'b01000,
      ST_CHECK = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_BITS-1:0]  clr_ff, clr_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic [HASH_BITS-1:0]  op_ff, op_in;
   logic [HASH_BITS-1:0]  acc_ff, acc_in;
   logic [HASH_BITS-1:0]  prod_ff;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [SLOT_BITS-1:0]  step_ff, step_in;
   logic [PROBE_BITS-1:0] probes_ff, probes_in;
   logic [NODE_BITS-1:0]  cur_node_ff, cur_node_in;
   logic [KEY_BITS-1:0]   cur_key_ff, cur_key_in;
   logic [LEN_BITS-1:0]   cur_len_ff, cur_len_in;
   logic [FILL_BITS-1:0]  fill_rd_ff;
   slot_entry_type        rd_ff;

   logic [HASH_BITS-1:0]  miss_hash_ff, miss_hash_in;
   logic [SLOT_BITS-1:0]  miss_slot_ff, miss_slot_in;
   logic [NODE_BITS-1:0]  miss_node_ff, miss_node_in;
   logic [KEY_BITS-1:0]   miss_key_ff, miss_key_in;
   logic [LEN_BITS-1:0]   miss_len_ff, miss_len_in;
   logic [FILL_BITS-1:0]  miss_fill_ff, miss_fill_in;
   logic                  miss_ready_ff, miss_ready_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [SCORE_BITS-1:0] rsp_score_ff, rsp_score_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [PROBE_BITS-1:0] rsp_probes_ff, rsp_probes_in;

   slot_entry_type        slot_mem [TOTAL_SLOTS];
   logic [FILL_BITS-1:0]  fill_mem [VERTICES];
   logic                  mem_we, mem_re, fill_we, fill_re;
   logic [ADDR_BITS-1:0]  mem_waddr, mem_raddr;
   slot_entry_type        mem_wdata;
   logic [FADDR_BITS-1:0] fill_waddr, fill_raddr;
   logic [FILL_BITS-1:0]  fill_wdata;

   logic [1:0]            phase;
   logic [HASH_BITS-1:0]  mix_const;
   logic [31:0]           mul_a, mul_b;
   logic [HASH_BITS-1:0]  mul_p;
   logic [HASH_BITS-1:0]  mix_out;
   logic [PROBE_BITS-1:0] probes_inc;
   logic                  key_match;
   logic [NEED_BITS-1:0]  need;

   // Shared multiplier: one 32x32 partial product per cycle.
   assign phase     = cnt_ff[1:0];
   assign mix_const = cnt_ff[2] ? MIX_B : MIX_A;
   assign mul_a     = (phase == 2'd2) ? op_ff[63:32] : op_ff[31:0];
   assign mul_b     = (phase == 2'd1) ? mix_const[63:32] : mix_const[31:0];
   assign mul_p     = mul_a * mul_b;
   assign mix_out   = xorshift_mix(acc_ff + {prod_ff[31:0], 32'd0});

   assign probes_inc = (probes_ff == PROBE_MAX) ? probes_ff : probes_ff + 1'b1;
   assign key_match  = rd_ff.valid && (rd_ff.hash == op_ff) &&
                       (rd_ff.length == cur_len_ff) && (rd_ff.key == cur_key_ff);
   assign need = NEED_BITS'((NEED_BITS'(fill_rd_ff) + NEED_BITS'(1)) *
                            NEED_BITS'(LOAD_DEN));

   assign job_pop = (state_ff == ST_IDLE) && job_valid && !rsp_valid_ff;
   assign back_stat.clearing = (state_ff == ST_CLEAR);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = rsp_kind_ff;
   assign rsp_ch.hit         = rsp_hit_ff;
   assign rsp_ch.found_score = rsp_score_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.probe_count = rsp_probes_ff;

   // Sequencer: clearing pass, dispatch, hash finish, probe loop.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      acc_in        = acc_ff;
      slot_in       = slot_ff;
      step_in       = step_ff;
      probes_in     = probes_ff;
      cur_node_in   = cur_node_ff;
      cur_key_in    = cur_key_ff;
      cur_len_in    = cur_len_ff;
      miss_hash_in  = miss_hash_ff;
      miss_slot_in  = miss_slot_ff;
      miss_node_in  = miss_node_ff;
      miss_key_in   = miss_key_ff;
      miss_len_in   = miss_len_ff;
      miss_fill_in  = miss_fill_ff;
      miss_ready_in = miss_ready_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_status_in = rsp_status_ff;
      rsp_probes_in = rsp_probes_ff;
      mem_we        = 1'b0;
      mem_waddr     = clr_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = ADDR_BITS'({cur_node_ff, slot_ff});
      fill_we       = 1'b0;
      fill_waddr    = FADDR_BITS'(clr_ff);
      fill_wdata    = '0;
      fill_re       = 1'b0;
      fill_raddr    = FADDR_BITS'(job.node);
      case (state_ff)
         ST_CLEAR: begin
            mem_we  = 1'b1;
            fill_we = (clr_ff < ADDR_BITS'(VERTICES));
            if (clr_ff == ADDR_BITS'(TOTAL_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (job_pop) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = 1'b0;
               rsp_score_in  = '0;
               rsp_probes_in = '0;
               rsp_status_in = STATUS_OK;
               miss_ready_in = 1'b0;
               if (job.is_insert) begin
                  rsp_kind_in = KIND_INSERT;
                  if (miss_ready_ff) begin
                     mem_we           = 1'b1;
                     mem_waddr        = ADDR_BITS'({miss_node_ff, miss_slot_ff});
                     mem_wdata.valid  = 1'b1;
                     mem_wdata.hash   = miss_hash_ff;
                     mem_wdata.length = miss_len_ff;
                     mem_wdata.key    = miss_key_ff;
                     mem_wdata.score  = job.score;
                     fill_we          = 1'b1;
                     fill_waddr       = FADDR_BITS'(miss_node_ff);
                     fill_wdata       = FILL_BITS'(miss_fill_ff + 1'b1);
                  end else begin
                     rsp_status_in = STATUS_NO_MISS;
                  end
               end else if (job.overflow) begin
                  rsp_kind_in   = KIND_LOOKUP;
                  rsp_status_in = STATUS_KEY_TOO_LONG;
               end else begin
                  // Lookup proper: the response is held back until the probe ends.
                  rsp_valid_in = 1'b0;
                  fill_re      = 1'b1;
                  op_in        = xorshift_mix(fnv_fold(job.hash, HASH_BITS'(job.length)));
                  cnt_in       = '0;
                  cur_node_in  = job.node;
                  cur_key_in   = job.key;
                  cur_len_in   = job.length;
                  state_in     = ST_MIX;
               end
            end
         end
         ST_MIX: begin
            // Low 64 bits of op * constant from three partial products.
            cnt_in = cnt_ff + 1'b1;
            case (phase)
               2'd1: acc_in = prod_ff;
               2'd2: acc_in = acc_ff + {prod_ff[31:0], 32'd0};
               2'd3: begin
                  op_in = mix_out;
                  if (cnt_ff[2]) begin
                     slot_in   = mix_out[SLOT_BITS-1:0];
                     step_in   = '0;
                     probes_in = '0;
                     state_in  = ST_READ;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            rsp_kind_in  = KIND_LOOKUP;
            rsp_hit_in   = 1'b0;
            rsp_score_in = '0;
            if (!rd_ff.valid) begin
               // Empty slot: a miss, insertable unless the table is loaded.
               rsp_valid_in  = 1'b1;
               rsp_probes_in = probes_ff;
               state_in      = ST_IDLE;
               if (need > ROOM) begin
                  rsp_status_in = STATUS_TABLE_FULL;
               end else begin
                  rsp_status_in = STATUS_OK;
                  miss_hash_in  = op_ff;
                  miss_slot_in  = slot_ff;
                  miss_node_in  = cur_node_ff;
                  miss_key_in   = cur_key_ff;
                  miss_len_in   = cur_len_ff;
                  miss_fill_in  = fill_rd_ff;
                  miss_ready_in = 1'b1;
               end
            end else if (key_match) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = 1'b1;
               rsp_score_in  = rd_ff.score;
               rsp_status_in = STATUS_OK;
               rsp_probes_in = probes_inc;
               state_in      = ST_IDLE;
            end else if (step_ff == LAST_STEP) begin
               // Every slot visited and none empty.
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_TABLE_FULL;
               rsp_probes_in = probes_inc;
               state_in      = ST_IDLE;
            end else begin
               slot_in   = SLOT_BITS'(slot_ff + 1'b1);
               step_in   = step_ff + 1'b1;
               probes_in = probes_inc;
               state_in  = ST_READ;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         miss_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         miss_ready_ff <= miss_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      op_ff         <= op_in;
      acc_ff        <= acc_in;
      prod_ff       <= mul_p;
      slot_ff       <= slot_in;
      step_ff       <= step_in;
      probes_ff     <= probes_in;
      cur_node_ff   <= cur_node_in;
      cur_key_ff    <= cur_key_in;
      cur_len_ff    <= cur_len_in;
      miss_hash_ff  <= miss_hash_in;
      miss_slot_ff  <= miss_slot_in;
      miss_node_ff  <= miss_node_in;
      miss_key_ff   <= miss_key_in;
      miss_len_ff   <= miss_len_in;
      miss_fill_ff  <= miss_fill_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_status_ff <= rsp_status_in;
      rsp_probes_ff <= rsp_probes_in;
   end

   // Slot memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= slot_mem[mem_raddr];
      end
   end

   // Fill count memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      if (fill_re) begin
         fill_rd_ff <= fill_mem[fill_raddr];
      end
   end

endmodule
`default_nettype wire

// ===== sv/hashed_score_cache_probe.sv =====
// Channel   Direction  Role
// req_ch    in         append key element, look up pending key, insert score
// rsp_ch    out        one word per lookup or insert, none per append
//
// A lookup finishes the hash on the shared 32x32 multiplier and then examines its slots one
// at a time through the single read port of the slot memory.
// Reset is synchronous; afterwards a clearing pass over all VERTICES * 128 slots
// (4096 by default) empties the slot memory, with req_ch held not ready.
// A two-word queue lets requests be taken while the back end or rsp_ch stalls.
// Top level of the hashed score cache probe.
// Depends on hcp_pkg, hcp_channels, hcp_queue, hcp_front, hcp_back and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_score_cache_probe_defines.svh"
module hashed_score_cache_probe import hcp_pkg::*; #(
   parameter int unsigned VERTICES = VERTICES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   hcp_req_if.sink   req_ch,
   hcp_rsp_if.source rsp_ch
);

   back_status_type  back_stat;
   queue_status_type q_stat;
   logic             job_push;
   logic             job_pop;
   job_type          push_job;
   job_type          head_job;

   // Front end: key gathering and classification.
   hcp_front #(.VERTICES(VERTICES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .back_stat (back_stat),
      .q_stat    (q_stat),
      .job_push  (job_push),
      .job       (push_job)
   );

   // Job queue between the two halves.
   hcp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head     (head_job),
      .q_stat   (q_stat)
   );

   // Back end: hash finish, probing and inserts.
   hcp_back #(.VERTICES(VERTICES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!q_stat.empty),
      .job       (head_job),
      .job_pop   (job_pop),
      .rsp_ch    (rsp_ch),
      .back_stat (back_stat)
   );

   // Checks on the block's own behaviour.
   `HCP_ASSERT_IMPLIES(a_no_req_while_clearing, clock, reset, back_stat.clearing, !req_ch.ready)
   `HCP_ASSERT_NEXT(a_no_rsp_after_clearing, clock, reset, back_stat.clearing, !rsp_ch.valid)
   `HCP_ASSERT_IMPLIES(a_insert_word_clean, clock, reset, rsp_ch.valid && (rsp_ch.result_kind == KIND_INSERT), !rsp_ch.hit && (rsp_ch.found_score == '0) && (rsp_ch.probe_count == '0))
   `HCP_ASSERT_IMPLIES(a_hit_is_ok, clock, reset, rsp_ch.valid && rsp_ch.hit, (rsp_ch.status == STATUS_OK) && (rsp_ch.probe_count != '0))

endmodule
`default_nettype wire

// ===== test/hcp_score_checker.sv =====
// Checker for the hashed score cache probe: watches both channels, predicts each answer
// and compares it field by field. Depends on hcp_pkg and the channel interfaces.
`timescale 1ns / 1ps
module hcp_score_checker import hcp_pkg::*; (
   input  logic clock,
   input  logic reset,
   hcp_req_if   req,
   hcp_rsp_if   rsp,
   output int   errors,
   output int   outstanding
);

   localparam logic [HASH_BITS-1:0] PRIME = 64'h00000100000001b3;
   localparam int TOTAL = VERTICES_DEFAULT * SLOTS_PER_TABLE;

   typedef struct {
      logic                  kind;
      logic                  hit;
      logic [SCORE_BITS-1:0] score;
      status_type            status;
      logic [PROBE_BITS-1:0] probes;
   } answer_type;

   answer_type            expected_answers[$];
   // Mirror of the slot memory and the per-vertex fill counts.
   bit                    slot_used[TOTAL];
   logic [HASH_BITS-1:0]  slot_hash[TOTAL];
   int                    slot_len[TOTAL];
   logic [KEY_BITS-1:0]   slot_key[TOTAL];
   logic [SCORE_BITS-1:0] slot_score[TOTAL];
   int                    fill[VERTICES_DEFAULT];
   // Key being gathered and the cursor left by the last insertable miss.
   logic [KEY_BITS-1:0]   pend_key;
   int                    pend_len;
   logic [HASH_BITS-1:0]  pend_hash;
   bit                    pend_overflow;
   logic [HASH_BITS-1:0]  cur_hash;
   logic [SLOT_BITS-1:0]  cur_slot;
   int                    cur_node;
   logic [KEY_BITS-1:0]   cur_key;
   int                    cur_len;
   bit                    cur_ready;

   function automatic logic [HASH_BITS-1:0] finalise_hash(logic [HASH_BITS-1:0] h, int len);
      h = (h ^ HASH_BITS'(len)) * PRIME;
      h = (h ^ (h >> MIX_SHIFT)) * MIX_A;
      h = (h ^ (h >> MIX_SHIFT)) * MIX_B;
      return h ^ (h >> MIX_SHIFT);
   endfunction

   function automatic bit same_key(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b, int len);
      for (int j = 0; j < len; j++)
         if (a[j*ELEM_BITS +: ELEM_BITS] != b[j*ELEM_BITS +: ELEM_BITS]) return 0;
      return 1;
   endfunction

   task automatic clear_pending();
      pend_key = '0;
      pend_len = 0;
      pend_hash = FNV_BASIS;
      pend_overflow = 0;
   endtask

   task automatic push(logic kind, logic hit, logic [SCORE_BITS-1:0] sc, status_type st,
                       int probes);
      answer_type a;
      a.kind = kind; a.hit = hit; a.score = sc; a.status = st;
      a.probes = PROBE_BITS'(probes);
      expected_answers.push_back(a);
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("%t: %s got %h want %h", $realtime, what, got, want);
      errors++;
   endtask

   // Linear probe of one vertex table for the pending key.
   task automatic predict_lookup(logic [NODE_BITS-1:0] node);
      logic [HASH_BITS-1:0] h;
      logic [SLOT_BITS-1:0] i;
      int base, n, probes, at;
      bit hit;
      cur_ready = 0;
      if (pend_overflow) begin
         clear_pending();
         push(KIND_LOOKUP, 0, 0, STATUS_KEY_TOO_LONG, 0);
         return;
      end
      h = finalise_hash(pend_hash, pend_len);
      base = int'(node) * SLOTS_PER_TABLE;
      i = h[SLOT_BITS-1:0];
      n = 0; probes = 0; hit = 0; at = 0;
      while (n < SLOTS_PER_TABLE && !hit && slot_used[base + i]) begin
         at = base + i;
         if (probes < 255) probes++;
         if (slot_hash[at] == h && slot_len[at] == pend_len &&
             same_key(slot_key[at], pend_key, pend_len)) begin
            hit = 1;
         end else begin
            i++;
            n++;
         end
      end
      if (hit) begin
         push(KIND_LOOKUP, 1, slot_score[at], STATUS_OK, probes);
      end else if (n == SLOTS_PER_TABLE ||
                   (fill[node] + 1) * LOAD_DEN > SLOTS_PER_TABLE * LOAD_NUM) begin
         push(KIND_LOOKUP, 0, 0, STATUS_TABLE_FULL, probes);
      end else begin
         cur_hash = h; cur_slot = i; cur_node = node;
         cur_key = pend_key; cur_len = pend_len; cur_ready = 1;
         push(KIND_LOOKUP, 0, 0, STATUS_OK, probes);
      end
      clear_pending();
   endtask

   task automatic predict_insert(logic [SCORE_BITS-1:0] sc);
      int at;
      if (!cur_ready) begin
         push(KIND_INSERT, 0, 0, STATUS_NO_MISS, 0);
         return;
      end
      at = cur_node * SLOTS_PER_TABLE + cur_slot;
      slot_used[at] = 1; slot_hash[at] = cur_hash; slot_len[at] = cur_len;
      slot_key[at] = cur_key; slot_score[at] = sc;
      fill[cur_node]++;
      cur_ready = 0;
      push(KIND_INSERT, 0, 0, STATUS_OK, 0);
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      answer_type a;
      if (reset) begin
         foreach (slot_used[k]) slot_used[k] = 0;
         foreach (fill[k]) fill[k] = 0;
         clear_pending();
         cur_hash = '0; cur_slot = '0; cur_node = 0; cur_key = '0; cur_len = 0;
         cur_ready = 0;
         expected_answers.delete();
      end else begin
         // Check a delivered word before predicting from a word taken in the same cycle.
         if (rsp.valid && rsp.ready) begin
            if (expected_answers.size() == 0) begin
               report("unexpected word, kind", rsp.result_kind, 0);
            end else begin
               a = expected_answers.pop_front();
               if (rsp.result_kind !== a.kind) report("result_kind", rsp.result_kind, a.kind);
               if (rsp.hit !== a.hit) report("hit", rsp.hit, a.hit);
               if (rsp.found_score !== a.score) report("found_score", rsp.found_score, a.score);
               if (rsp.status !== a.status) report("status", rsp.status, a.status);
               if (rsp.probe_count !== a.probes) report("probe_count", rsp.probe_count, a.probes);
            end
         end
         if (req.valid && req.ready) begin
            case (req.command)
               CMD_APPEND: begin
                  if (pend_len >= MAX_KEY_LENGTH) begin
                     pend_overflow = 1;
                  end else begin
                     pend_key[pend_len*ELEM_BITS +: ELEM_BITS] = req.key_element;
                     pend_len++;
                     pend_hash = (pend_hash ^ HASH_BITS'(req.key_element)) * PRIME;
                  end
               end
               CMD_LOOKUP: predict_lookup(req.node);
               CMD_INSERT: predict_insert(req.score);
               default: ;
            endcase
         end
      end
      outstanding = expected_answers.size();
   end

endmodule

// ===== test/tb_hashed_score_cache_probe.sv =====
// Testbench top for the hashed score cache probe: clock, reset, stimulus, flow control
// and verdict. Depends on hcp_pkg, the channel interfaces and hcp_score_checker.
`timescale 1ns / 1ps
module tb_hashed_score_cache_probe;
   import hcp_pkg::*;

   localparam int IDLE_LIMIT = 30000;
   localparam int ITEM_TARGET = 650;

   logic clock = 0;
   logic reset = 1;
   int   errors, outstanding, items, idle_cycles;
   logic [KEY_BITS-1:0] key_pool[16];
   int   len_pool[16];

   hcp_req_if req_ch();
   hcp_rsp_if rsp_ch();

   hashed_score_cache_probe dut (.clock(clock), .reset(reset), .req_ch(req_ch),
                                 .rsp_ch(rsp_ch));
   hcp_score_checker checker_i (.clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
                                .errors(errors), .outstanding(outstanding));

   always #10 clock = ~clock;

   // Offer one word after a random gap and hold it until it is taken.
   task automatic send(command_type cmd, logic [NODE_BITS-1:0] node,
                       logic [ELEM_BITS-1:0] elem, logic [SCORE_BITS-1:0] sc);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.command <= cmd;
      req_ch.node <= node;
      req_ch.key_element <= elem;
      req_ch.score <= sc;
      do @(posedge clock); while (!req_ch.ready);
      items++;
   endtask

   task automatic send_key(logic [KEY_BITS-1:0] key, int len);
      for (int j = 0; j < len; j++)
         send(CMD_APPEND, $urandom, key[j*ELEM_BITS +: ELEM_BITS], {$urandom, $urandom});
   endtask

   function automatic logic [SCORE_BITS-1:0] rand_score();
      return {$urandom, $urandom};
   endfunction

   // Response side: random stalls, one long hold-off while the sender keeps going.
   initial begin
      int waits, taken;
      rsp_ch.ready <= 0;
      taken = 0;
      forever begin
         waits = (taken == 80) ? 400 : $urandom_range(0, 10);
         if (taken > 300 && taken < 340) waits = 0;
         if (waits > 0) begin
            rsp_ch.ready <= 0;
            repeat (waits) @(posedge clock);
         end
         rsp_ch.ready <= 1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("hashed_score_cache_probe: mismatch");
         $finish;
      end
   end

   initial begin
      int k, sel;
      command_type cmd;
      idle_cycles = 0;
      items = 0;
      req_ch.valid <= 0;
      req_ch.command <= CMD_APPEND;
      req_ch.node <= '0;
      req_ch.key_element <= '0;
      req_ch.score <= '0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // Directed: insert with no miss, empty key miss then hit, longest key with
      // extreme elements, overlong key, the unused command, and a lookup that
      // cancels the miss cursor.
      send(CMD_INSERT, 0, 0, '1);
      send(CMD_LOOKUP, 0, 0, 0);
      send(CMD_INSERT, 0, 0, '1);
      send(CMD_LOOKUP, 0, 0, 0);
      send_key({8{5'd31}}, 8);
      send(CMD_LOOKUP, 31, 0, 0);
      send(CMD_INSERT, 0, 0, '0);
      send_key({8{5'd31}}, 8);
      send(CMD_LOOKUP, 31, 31, '1);
      send_key('0, 8);
      send(CMD_APPEND, 0, 0, 0);
      send(CMD_LOOKUP, 3, 0, 0);
      send(command_type'(2'd3), 31, 31, '1);
      send(CMD_LOOKUP, 5, 0, 0);
      send(CMD_LOOKUP, 5, 0, 0);
      send(CMD_INSERT, 0, 0, rand_score());

      // Let every answer come back before the random part, then wait on the clock
      // so that the checker has seen the last word.
      req_ch.valid <= 0;
      @(posedge clock);
      wait (outstanding == 0);
      @(posedge clock);

      for (k = 0; k < 16; k++) begin
         key_pool[k] = {$urandom, $urandom};
         len_pool[k] = $urandom_range(0, MAX_KEY_LENGTH);
      end

      // Fill one vertex table past its load limit with two-element keys.
      for (k = 0; k < 85; k++) begin
         send_key({$urandom, $urandom}, 2);
         send(CMD_LOOKUP, 9, 0, 0);
         send(CMD_INSERT, 0, 0, rand_score());
      end

      // Random sequences: mostly append, lookup, insert; some noise and broken ones.
      while (items < ITEM_TARGET) begin
         k = $urandom_range(0, 99);
         if (k < 10) begin
            cmd = command_type'($urandom_range(0, 3));
            send(cmd, $urandom, $urandom, rand_score());
         end else if (k < 15) begin
            send_key({$urandom, $urandom}, MAX_KEY_LENGTH);
            repeat ($urandom_range(1, 3)) send(CMD_APPEND, 0, $urandom, 0);
            send(CMD_LOOKUP, $urandom, 0, 0);
            if ($urandom_range(0, 1)) send(CMD_INSERT, 0, 0, rand_score());
         end else begin
            sel = $urandom_range(0, 15);
            if ($urandom_range(0, 9) < 6)
               send_key(key_pool[sel], len_pool[sel]);
            else
               send_key({$urandom, $urandom}, $urandom_range(0, MAX_KEY_LENGTH));
            send(CMD_LOOKUP, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3),
                 $urandom, rand_score());
            if ($urandom_range(0, 9) < 7) send(CMD_INSERT, $urandom, $urandom, rand_score());
         end
      end

      req_ch.valid <= 0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (400) @(posedge clock);
      if (errors == 0 && outstanding == 0)
         $display("hashed_score_cache_probe: match");
      else
         $display("hashed_score_cache_probe: mismatch");
      $finish;
   end

endmodule
